// ===== hdl/signed_int_to_decimal_ascii_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal ASCII converter
// Shared property forms for the assertion blocks of this block. The
// property is sampled on i_clk and is held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SITDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SITDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sitda_pkg.sv =====
// ----------------------------------------------------------------------------
// sitda_pkg
// Widths, character codes and the pipeline stage type shared by the
// signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

    // Width of the two's-complement input value.
    localparam int VALUE_WIDTH = 32;

    // Input bits shifted into the BCD register by each pipeline stage.
    localparam int STEP_BITS = 4;
    localparam int NUM_STAGES = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int BIN_WIDTH = NUM_STAGES * STEP_BITS;

    localparam logic [63:0] RADIX = 64'd10;

    // Number of decimal digits in the largest magnitude, 2^(VALUE_WIDTH-1).
    function automatic int f_num_digits(int width);
        logic [63:0] mag;
        int          n;
        mag = 64'd1 << (width - 1);
        n   = 0;
        for (int k = 0; k < 20; k++) begin
            if (mag != 64'd0) begin
                n   = n + 1;
                mag = mag / RADIX;
            end
        end
        return n;
    endfunction

    localparam int NUM_DIGITS = f_num_digits(VALUE_WIDTH);
    localparam int BCD_WIDTH = NUM_DIGITS * 4;
    localparam int IDX_WIDTH = $clog2(NUM_DIGITS);

    // Output character codes.
    localparam int CHAR_WIDTH = 6;
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 6'd48;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

    // One item in flight through the conversion pipeline.
    typedef struct packed {
        logic                 valid;
        logic                 negative;
        logic [BIN_WIDTH-1:0] bin;
        logic [BCD_WIDTH-1:0] bcd;
    } t_stage;

endpackage

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer to its decimal text, one ASCII character per
// output item, most significant character first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid, i_value and o_stall. A value is taken at a clock
//   edge with i_valid high and o_stall low.
//   Output channel: o_valid, o_ascii_char, o_last_char and i_stall. Each item
//   carries '-' or a digit; o_last_char marks the final character of a number.
//   Negative numbers start with '-', zero gives "0", and no leading zeros
//   are sent. The most negative value gives "-2147483648".
//   Path: after its value is taken into the input register, a number passes
//   the 8 binary-to-BCD stages, the digit holding register and the output
//   register before its first character is shown.
//   Throughput: one character per cycle while i_stall is low; a number has
//   1 to 11 characters. The single character sequencer at the end of the
//   pipeline sets that rate, and the stages ahead of it fill while it works.
//   Reset (i_rst_n low, synchronous) empties every stage; o_stall is high
//   while reset is held.
//   When i_stall is high the output item holds, the stages behind it keep
//   filling up, and o_stall rises once every stage is full.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] i_value,
    output logic                                     o_stall,
    output logic                                     o_valid,
    output logic [sitda_pkg::CHAR_WIDTH-1:0]         o_ascii_char,
    output logic                                     o_last_char,
    input  logic                                     i_stall
);

    logic                              w_neg;
    logic [sitda_pkg::VALUE_WIDTH-1:0] w_mag;
    sitda_pkg::t_stage                 n_s0;
    sitda_pkg::t_stage                 r_s0;
    logic                              w_s0_ready;
    sitda_pkg::t_stage                 w_stage [0:sitda_pkg::NUM_STAGES];
    logic                              w_ready [0:sitda_pkg::NUM_STAGES];

    // Sign and unsigned magnitude; the most negative value maps to 2^(W-1).
    assign w_neg = i_value[sitda_pkg::VALUE_WIDTH-1];
    assign w_mag = w_neg ? (~$unsigned(i_value) + {{(sitda_pkg::VALUE_WIDTH-1){1'b0}}, 1'b1})
                         : $unsigned(i_value);

    always_comb begin
        n_s0.valid    = i_valid;
        n_s0.negative = w_neg;
        n_s0.bin      = sitda_pkg::BIN_WIDTH'(w_mag);
        n_s0.bcd      = '0;
    end

    // Input register.
    assign w_s0_ready = !r_s0.valid || w_ready[0];
    assign o_stall    = !w_s0_ready || !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (w_s0_ready) begin
            r_s0 <= n_s0;
        end
    end

    assign w_stage[0] = r_s0;

    // Binary to BCD pipeline.
    for (genvar g = 0; g < sitda_pkg::NUM_STAGES; g++) begin : g_dabble
        sitda_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_stage[g]),
            .o_ready (w_ready[g]),
            .o_stage (w_stage[g+1]),
            .i_ready (w_ready[g+1])
        );
    end

    // Character output.
    sitda_serializer u_serializer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stage      (w_stage[sitda_pkg::NUM_STAGES]),
        .o_ready      (w_ready[sitda_pkg::NUM_STAGES]),
        .o_valid      (o_valid),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char),
        .i_stall      (i_stall)
    );

endmodule

// ===== hdl/sitda_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// sitda_dabble_stage
// One register stage of the binary to BCD converter. Shifts STEP_BITS bits
// of the binary magnitude into the BCD digits, correcting digits of five
// or more before each shift.
// ----------------------------------------------------------------------------
module sitda_dabble_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sitda_pkg::t_stage i_stage,
    output logic              o_ready,
    output sitda_pkg::t_stage o_stage,
    input  logic              i_ready
);

    logic [sitda_pkg::BIN_WIDTH-1:0] n_bin;
    logic [sitda_pkg::BCD_WIDTH-1:0] n_bcd;
    sitda_pkg::t_stage               n_stage;
    sitda_pkg::t_stage               r_stage;

    // Add-three correction and shift, once per input bit of this stage.
    always_comb begin
        n_bin = i_stage.bin;
        n_bcd = i_stage.bcd;
        for (int s = 0; s < sitda_pkg::STEP_BITS; s++) begin
            for (int d = 0; d < sitda_pkg::NUM_DIGITS; d++) begin
                if (n_bcd[4*d +: 4] >= 4'd5) begin
                    n_bcd[4*d +: 4] = n_bcd[4*d +: 4] + 4'd3;
                end
            end
            {n_bcd, n_bin} = {n_bcd, n_bin} << 1;
        end
    end

    always_comb begin
        n_stage.valid    = i_stage.valid;
        n_stage.negative = i_stage.negative;
        n_stage.bin      = n_bin;
        n_stage.bcd      = n_bcd;
    end

    // The stage takes a new item when it is empty or its item moves on.
    assign o_ready = !r_stage.valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (o_ready) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== hdl/sitda_serializer.sv =====
// ----------------------------------------------------------------------------
// sitda_serializer
// Holds one converted item, finds its leading digit and sends the sign and
// the digits one character per cycle while i_stall is low, through a registered output.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_assert.svh"

module sitda_serializer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sitda_pkg::t_stage                i_stage,
    output logic                             o_ready,
    output logic                             o_valid,
    output logic [sitda_pkg::CHAR_WIDTH-1:0] o_ascii_char,
    output logic                             o_last_char,
    input  logic                             i_stall
);

    typedef struct packed {
        logic                           valid;
        logic                           negative;
        logic [sitda_pkg::BCD_WIDTH-1:0] bcd;
        logic [sitda_pkg::IDX_WIDTH-1:0] msd;
    } t_lead;

    t_lead                              r_lead;
    t_lead                              n_lead;
    logic [sitda_pkg::IDX_WIDTH-1:0]    n_msd;
    logic                               r_sign_done;
    logic                               r_mid;
    logic [sitda_pkg::IDX_WIDTH-1:0]    r_idx;
    logic                               r_out_valid;
    logic [sitda_pkg::CHAR_WIDTH-1:0]   r_out_char;
    logic                               r_out_last;

    logic                               sign_char;
    logic [sitda_pkg::IDX_WIDTH-1:0]    cur_idx;
    logic [3:0]                         cur_digit;
    logic                               cur_last;
    logic [sitda_pkg::CHAR_WIDTH-1:0]   cur_char;
    logic                               out_en;
    logic                               fire;

    // Highest nonzero digit of the incoming item; zero gives index zero.
    always_comb begin
        n_msd = '0;
        for (int d = 0; d < sitda_pkg::NUM_DIGITS; d++) begin
            if (i_stage.bcd[4*d +: 4] != 4'd0) begin
                n_msd = sitda_pkg::IDX_WIDTH'(d);
            end
        end
    end

    always_comb begin
        n_lead.valid    = i_stage.valid;
        n_lead.negative = i_stage.negative;
        n_lead.bcd      = i_stage.bcd;
        n_lead.msd      = n_msd;
    end

    // Character selection for the held item.
    assign sign_char = r_lead.negative && !r_sign_done;
    assign cur_idx   = r_mid ? r_idx : r_lead.msd;
    assign cur_digit = r_lead.bcd[cur_idx*4 +: 4];
    assign cur_last  = !sign_char && (cur_idx == '0);
    assign cur_char  = sign_char ? sitda_pkg::CHAR_MINUS
                                 : sitda_pkg::CHAR_ZERO + {2'b00, cur_digit};

    // The output register loads when empty or when its item is taken.
    assign out_en  = !r_out_valid || !i_stall;
    assign fire    = r_lead.valid && out_en;
    assign o_ready = !r_lead.valid || (fire && cur_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead.valid <= 1'b0;
            r_sign_done  <= 1'b0;
            r_mid        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (out_en) begin
                r_out_valid <= r_lead.valid;
                r_out_char  <= cur_char;
                r_out_last  <= cur_last;
            end
            // Step through the sign, then the digits from the leading one down.
            if (fire) begin
                if (sign_char) begin
                    r_sign_done <= 1'b1;
                end else if (cur_last) begin
                    r_sign_done <= 1'b0;
                    r_mid       <= 1'b0;
                end else begin
                    r_mid <= 1'b1;
                    r_idx <= cur_idx - sitda_pkg::IDX_WIDTH'(1);
                end
            end
            if (o_ready) begin
                r_lead <= n_lead;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_ascii_char = r_out_char;
    assign o_last_char  = r_out_last;

    // Checks on the character sequencing.
    `SITDA_ASSERT_NOW(a_sign_not_last, r_out_valid && (r_out_char == sitda_pkg::CHAR_MINUS), !r_out_last, "sign character flagged as last")
    `SITDA_ASSERT_NOW(a_idx_below_msd, r_lead.valid && r_mid, r_idx < r_lead.msd, "digit index above leading digit")
    `SITDA_ASSERT_NEXT(a_clear_after_last, fire && cur_last, !r_mid && !r_sign_done, "sequencer not cleared after last character")
    `SITDA_ASSERT_NOW(a_msd_nonzero, r_lead.valid && (r_lead.msd != '0), r_lead.bcd[r_lead.msd*4 +: 4] != 4'd0, "leading digit is zero")

endmodule

// ===== tb/sv/signed_int_to_decimal_ascii_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Self-checking testbench for the signed integer to decimal ASCII converter.
// Signed values are fed in, and each one is turned here into its expected
// character run. Every character that leaves the block is compared with
// the oldest expected character. Directed edge values come first, then
// random values of every digit length. In most tests both sides idle and stall at random.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;

    // Idle behavior of the sender and of the receiver.
    typedef enum int {
        IDLE_NONE,
        IDLE_NORMAL,
        IDLE_HEAVY
    } t_idle_mode;

    // One expected character of a number's text.
    typedef struct packed {
        logic [sitda_pkg::CHAR_WIDTH-1:0] ch;
        logic                             last;
    } t_text_char;

    logic                                     i_clk = 1'b0;
    logic                                     i_rst_n = 1'b0;
    logic                                     i_valid = 1'b0;
    logic signed [sitda_pkg::VALUE_WIDTH-1:0] i_value = '0;
    logic                                     o_stall;
    logic                                     o_valid;
    logic [sitda_pkg::CHAR_WIDTH-1:0]         o_ascii_char;
    logic                                     o_last_char;
    logic                                     i_stall = 1'b0;

    t_text_char pending_text[$];
    t_idle_mode send_idle = IDLE_NONE;
    t_idle_mode sink_idle = IDLE_NONE;
    int         error_count = 0;
    int         numbers_sent = 0;
    int         negatives_sent = 0;
    int         chars_checked = 0;
    int         quiet_cycles = 0;

    signed_int_to_decimal_ascii u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_value      (i_value),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char),
        .i_stall      (i_stall)
    );

    always #4 i_clk = ~i_clk;

    // Work out the decimal text of one value and queue its characters.
    function automatic void queue_decimal_text(input logic [sitda_pkg::VALUE_WIDTH-1:0] raw);
        logic [sitda_pkg::VALUE_WIDTH-1:0] mag;
        logic [63:0]                       rem;
        logic [3:0]                        digit_buf [0:19];
        int                                n;
        t_text_char                        c;
        mag = raw[sitda_pkg::VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
        rem = 64'(mag);
        n = 0;
        do begin
            digit_buf[n] = 4'(rem % 64'd10);
            n++;
            rem = rem / 64'd10;
        end while (rem != 64'd0);
        if (raw[sitda_pkg::VALUE_WIDTH-1]) begin
            c.ch = sitda_pkg::CHAR_MINUS;
            c.last = 1'b0;
            pending_text.push_back(c);
        end
        for (int k = n - 1; k >= 0; k--) begin
            c.ch = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_WIDTH'(digit_buf[k]);
            c.last = (k == 0);
            pending_text.push_back(c);
        end
    endfunction

    // Gap length: mostly zero or short, now and then long.
    function automatic int pick_gap(input t_idle_mode mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            IDLE_NONE: begin
                return 0;
            end
            IDLE_NORMAL: begin
                if (r < 55) return 0;
                if (r < 92) return $urandom_range(1, 3);
                return $urandom_range(8, 30);
            end
            default: begin
                if (r < 20) return 0;
                if (r < 70) return $urandom_range(1, 6);
                return $urandom_range(10, 40);
            end
        endcase
    endfunction

    // Random value with a random digit count and sign; some fully random words.
    function automatic logic [sitda_pkg::VALUE_WIDTH-1:0] random_value();
        int unsigned                       digits;
        int unsigned                       top;
        logic [sitda_pkg::VALUE_WIDTH-1:0] mag;
        digits = $urandom_range(1, 12);
        if (digits >= 10) return $urandom();
        top = 1;
        for (int k = 0; k < digits; k++) top = top * 10;
        mag = $urandom_range(0, top - 1);
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
    endfunction

    // Present one item, wait until it is taken, then maybe leave a gap.
    task automatic send_value(input logic [sitda_pkg::VALUE_WIDTH-1:0] v);
        int gap;
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        queue_decimal_text(v);
        numbers_sent++;
        if (v[sitda_pkg::VALUE_WIDTH-1]) negatives_sent++;
        gap = pick_gap(send_idle);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver stall pattern: runs of stall and non-stall cycles.
    int  stall_run = 0;
    logic stall_now = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n || sink_idle == IDLE_NONE) begin
            stall_run = 0;
            stall_now = 1'b0;
        end else if (stall_run > 0) begin
            stall_run--;
        end else begin
            stall_now = (pick_gap(sink_idle) != 0);
            stall_run = stall_now ? pick_gap(sink_idle) : $urandom_range(0, 8);
        end
        i_stall <= stall_now;
    end

    // Compare each accepted character with the oldest expected one.
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_text.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual char %0d last %0b",
                         $time, o_ascii_char, o_last_char);
                error_count++;
            end else begin
                want = pending_text.pop_front();
                chars_checked++;
                if (o_ascii_char !== want.ch) begin
                    $display("%0t: character mismatch: expected %0d, actual %0d",
                             $time, want.ch, o_ascii_char);
                    error_count++;
                end
                if (o_last_char !== want.last) begin
                    $display("%0t: last flag mismatch: expected %0b, actual %0b",
                             $time, want.last, o_last_char);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Zero, single digits, carries into new digit counts and both extremes.
    task automatic test_edge_values();
        send_idle = IDLE_NONE;
        sink_idle = IDLE_NONE;
        send_value(32'sd0);
        send_value(32'sd1);
        send_value(-32'sd1);
        send_value(32'sd9);
        send_value(32'sd10);
        send_value(-32'sd10);
        send_value(32'sd99);
        send_value(32'sd100);
        send_value(-32'sd999999999);
        send_value(32'sd1000000000);
        send_value(32'sd1234567890);
        send_value(32'sh7FFFFFFF);
        send_value(32'sh80000000);
        send_value(32'sh80000001);
        send_value(32'shFFFFFFFE);
        send_value(32'sh55555555);
        send_value(32'shAAAAAAAA);
        send_value(32'sd0);
    endtask

    // Random values of every length with gaps and stalls on both sides.
    task automatic test_random_values();
        send_idle = IDLE_NORMAL;
        sink_idle = IDLE_NORMAL;
        repeat (140) send_value(random_value());
    endtask

    // Sender holds off until the whole pipeline has drained, several times.
    task automatic test_pause_until_drained();
        send_idle = IDLE_NORMAL;
        sink_idle = IDLE_NORMAL;
        repeat (4) begin
            repeat (5) send_value(random_value());
            i_valid <= 1'b0;
            while (pending_text.size() != 0) @(posedge i_clk);
        end
        send_value(32'sh80000000);
    endtask

    // Back to back items with the receiver always ready.
    task automatic test_full_rate();
        send_idle = IDLE_NONE;
        sink_idle = IDLE_NONE;
        repeat (50) send_value(random_value());
    endtask

    // Receiver stalls hard so that the pipeline backs up into the sender.
    task automatic test_heavy_stall();
        send_idle = IDLE_NONE;
        sink_idle = IDLE_HEAVY;
        repeat (45) send_value(random_value());
        send_idle = IDLE_HEAVY;
        repeat (25) send_value(random_value());
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_values();
        test_random_values();
        test_pause_until_drained();
        test_full_rate();
        test_heavy_stall();

        // Let every outstanding character arrive, then a little longer.
        i_valid <= 1'b0;
        while (pending_text.size() != 0) @(posedge i_clk);
        sink_idle = IDLE_NONE;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d numbers (%0d negative), %0d characters checked.",
                 numbers_sent, negatives_sent, chars_checked);
        $display("Covered edge values, all digit lengths, full rate and heavy back-pressure.");
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
